### rtl/core/prxyz_pkg.sv
// Shared constants, types, trig table and arithmetic helpers for the point rotator.
package prxyz_pkg;

    localparam int COORD_W  = 16;              // input coordinate width
    localparam int OUT_W    = COORD_W + 1;     // result coordinate width
    localparam int CW       = OUT_W + 1;       // internal coordinate width
    localparam int FRAC     = 16;              // trig fraction bits
    localparam int TRIG_W   = FRAC + 2;        // signed trig value, holds +-1.0
    localparam int PW       = CW + TRIG_W;     // product width
    localparam int SW       = PW + 1;          // sum of two products
    localparam int ANG_W    = 10;              // configured angle width
    localparam int DEG_W    = 9;               // reduced angle, 0..359
    localparam int TAB_IW   = 7;               // table index, 0..90
    localparam int TBL_FRAC = 30;

    localparam int IN_TDATA_W  = 3 * COORD_W;
    localparam int OUT_TDATA_W = ((3 * OUT_W + 7) / 8) * 8;
    localparam int PAD_W       = OUT_TDATA_W - 3 * OUT_W;
    localparam int NSTG        = 6;

    localparam logic [DEG_W-1:0] DEG_QUARTER = 9'd90;
    localparam logic [DEG_W-1:0] DEG_HALF    = 9'd180;
    localparam logic [DEG_W-1:0] DEG_3Q      = 9'd270;
    localparam logic [DEG_W-1:0] DEG_FULL    = 9'd360;
    localparam logic signed [ANG_W+1:0] DEG_FULL_S = 12'sd360;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    // configuration register indexes
    localparam logic [1:0] CFG_ANGLE_X = 2'd0;
    localparam logic [1:0] CFG_ANGLE_Y = 2'd1;
    localparam logic [1:0] CFG_ANGLE_Z = 2'd2;

    typedef logic signed [TRIG_W-1:0] t_trig;
    typedef logic signed [CW-1:0]     t_coord;
    typedef logic signed [PW-1:0]     t_prod;
    typedef logic signed [SW-1:0]     t_sum;
    typedef t_trig t_sin_tab [0:90];

    localparam t_trig COS_ONE = t_trig'(1 << FRAC);
    localparam t_sum  HALF    = t_sum'(1 << (FRAC - 1));

    // fixed-point multiply in Q30 with round to nearest
    function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
        return (a * b + (64'd1 << (TBL_FRAC - 1))) >> TBL_FRAC;
    endfunction

    // sine of d degrees, d in 0..90, in Q30, by a nine-term Taylor series
    function automatic logic [63:0] sin_q30_quarter(input int unsigned d);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] acc;
        if (d == 0) begin
            return 64'd0;
        end
        if (d >= 90) begin
            return 64'd1 << TBL_FRAC;
        end
        x    = (64'(d) * PI_Q30 + 64'd90) / 64'd180;
        x2   = mul_q30(x, x);
        acc  = x;
        term = mul_q30(x, x2);
        term = (term + 64'd3) / 64'd6;
        acc  = acc - term;
        term = mul_q30(term, x2);
        term = (term + 64'd10) / 64'd20;
        acc  = acc + term;
        term = mul_q30(term, x2);
        term = (term + 64'd21) / 64'd42;
        acc  = acc - term;
        term = mul_q30(term, x2);
        term = (term + 64'd36) / 64'd72;
        acc  = acc + term;
        term = mul_q30(term, x2);
        term = (term + 64'd55) / 64'd110;
        acc  = acc - term;
        term = mul_q30(term, x2);
        term = (term + 64'd78) / 64'd156;
        acc  = acc + term;
        term = mul_q30(term, x2);
        term = (term + 64'd105) / 64'd210;
        acc  = acc - term;
        term = mul_q30(term, x2);
        term = (term + 64'd136) / 64'd272;
        acc  = acc + term;
        return acc;
    endfunction

    function automatic t_sin_tab build_sin_tab();
        t_sin_tab t;
        logic [63:0] v;
        for (int d = 0; d <= 90; d++) begin
            v    = sin_q30_quarter(d);
            v    = (v + (64'd1 << (TBL_FRAC - FRAC - 1))) >> (TBL_FRAC - FRAC);
            t[d] = t_trig'(v);
        end
        return t;
    endfunction

    localparam t_sin_tab SIN_TAB = build_sin_tab();

    // reduce a configured angle to 0..359
    function automatic logic [DEG_W-1:0] deg_mod360(input logic signed [ANG_W-1:0] a);
        logic signed [ANG_W+1:0] v;
        v = (ANG_W + 2)'(a);
        if (v < 0) begin
            v = v + DEG_FULL_S;
        end
        if (v < 0) begin
            v = v + DEG_FULL_S;
        end
        if (v >= DEG_FULL_S) begin
            v = v - DEG_FULL_S;
        end
        return DEG_W'(v);
    endfunction

    // sine of d degrees, d in 0..359, from the quarter-wave table
    function automatic t_trig sin_deg(input logic [DEG_W-1:0] d);
        logic [DEG_W-1:0] i;
        logic             neg;
        t_trig            v;
        if (d <= DEG_QUARTER) begin
            i   = d;
            neg = 1'b0;
        end else if (d <= DEG_HALF) begin
            i   = DEG_HALF - d;
            neg = 1'b0;
        end else if (d <= DEG_3Q) begin
            i   = d - DEG_HALF;
            neg = 1'b1;
        end else begin
            i   = DEG_FULL - d;
            neg = 1'b1;
        end
        v = SIN_TAB[i[TAB_IW-1:0]];
        return neg ? -v : v;
    endfunction

    // cosine of d degrees as sine of d + 90
    function automatic t_trig cos_deg(input logic [DEG_W-1:0] d);
        logic [DEG_W-1:0] e;
        if (d >= DEG_3Q) begin
            e = d - DEG_3Q;
        end else begin
            e = d + DEG_QUARTER;
        end
        return sin_deg(e);
    endfunction

    // drop the trig fraction, halves away from zero
    function automatic t_coord round_frac(input t_sum v);
        t_sum        m;
        logic [SW-1:0] q;
        if (!v[SW-1]) begin
            q = (v + HALF) >> FRAC;
            return t_coord'(q);
        end
        m = -v;
        q = (m + HALF) >> FRAC;
        return -t_coord'(q);
    endfunction

endpackage

### rtl/core/point_rotate_xyz_degrees.sv
// Pipelined three-axis point rotator, x then y then z, by whole-degree angles.
//
// Use: one point per request on the s_axis channel, one rotated point per
// request on the m_axis channel, in the same order. Angles are written on the
// plain write port (i_cfg_we, i_cfg_idx, i_cfg_data) while the pipe is empty;
// index 0 is about x, 1 about y, 2 about z, each a signed count of degrees.
// A write converts the angle to a sine and cosine pair at once, so an angle
// of zero or a multiple of 360 leaves its axis unchanged.
// Throughput: one point per cycle while m_axis_tready is high; six register stages,
// each axis taking a multiply stage (four 18x18 products) and an add and round stage.
// Reset (synchronous, active low) empties the pipe and sets every angle to 0.
// When the receiver stalls, each full stage holds while the one after it holds;
// empty stages keep filling, so up to six points are taken before
// s_axis_tready falls. Nothing is dropped or repeated.
module point_rotate_xyz_degrees
    import prxyz_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_idx,
    input  logic [ANG_W-1:0]       i_cfg_data,
    // point requests in
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // point_x, point_y, point_z
    // rotated points out
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata   // rotated_x, rotated_y, rotated_z, zero pad
);

    // trig pairs, one per axis, held in the order of the register indexes
    t_trig r_sin [3];
    t_trig r_cos [3];

    logic [DEG_W-1:0] cfg_deg;
    t_trig            cfg_sin;
    t_trig            cfg_cos;

    // pipe control
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] rdy;
    logic [NSTG-1:0] ld;

    // stage data
    t_coord r_s1_x;
    t_prod  r_s1_p [4];
    t_coord r_s2_x, r_s2_y, r_s2_z;
    t_coord r_s3_y;
    t_prod  r_s3_p [4];
    t_coord r_s4_x, r_s4_y, r_s4_nz;
    t_coord r_s5_nz;
    t_prod  r_s5_p [4];
    logic [OUT_W-1:0] r_s6_x, r_s6_y, r_s6_z;

    t_coord in_x, in_y, in_z;
    t_coord s3_nz;

    // ---------------------------------------------------------------
    // Configuration: reduce the angle and look up its sine and cosine
    // ---------------------------------------------------------------
    assign cfg_deg = deg_mod360(i_cfg_data);
    assign cfg_sin = sin_deg(cfg_deg);
    assign cfg_cos = cos_deg(cfg_deg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_sin[k] <= '0;
                r_cos[k] <= COS_ONE;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ANGLE_X: begin
                    r_sin[CFG_ANGLE_X] <= cfg_sin;
                    r_cos[CFG_ANGLE_X] <= cfg_cos;
                end
                CFG_ANGLE_Y: begin
                    r_sin[CFG_ANGLE_Y] <= cfg_sin;
                    r_cos[CFG_ANGLE_Y] <= cfg_cos;
                end
                CFG_ANGLE_Z: begin
                    r_sin[CFG_ANGLE_Z] <= cfg_sin;
                    r_cos[CFG_ANGLE_Z] <= cfg_cos;
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Flow control: a stage advances when it is empty or its successor
    // advances; a stage loads when it advances and its source is valid.
    // ---------------------------------------------------------------
    always_comb begin
        rdy[NSTG-1] = !r_vld[NSTG-1] || m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
        ld[0] = rdy[0] && s_axis_tvalid;
        for (int k = 1; k < NSTG; k++) begin
            ld[k] = rdy[k] && r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign s_axis_tready = rdy[0];
    assign m_axis_tvalid = r_vld[NSTG-1];
    assign m_axis_tdata  = {PAD_W'(0), r_s6_z, r_s6_y, r_s6_x};

    // unpack and widen the incoming point
    assign in_x = t_coord'($signed(s_axis_tdata[COORD_W-1:0]));
    assign in_y = t_coord'($signed(s_axis_tdata[2*COORD_W-1:COORD_W]));
    assign in_z = t_coord'($signed(s_axis_tdata[3*COORD_W-1:2*COORD_W]));

    // about y the pair is (x, -z)
    assign s3_nz = -r_s2_z;

    // ---------------------------------------------------------------
    // Datapath: per axis, pair (a, b) gives
    //   a' = a*cos + b*sin ; b' = b*cos - a*sin
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        // stage 1: products about x, pair (y, z)
        if (ld[0]) begin
            r_s1_x    <= in_x;
            r_s1_p[0] <= in_y * r_cos[CFG_ANGLE_X];
            r_s1_p[1] <= in_z * r_sin[CFG_ANGLE_X];
            r_s1_p[2] <= in_y * r_sin[CFG_ANGLE_X];
            r_s1_p[3] <= in_z * r_cos[CFG_ANGLE_X];
        end
        // stage 2: round y and z
        if (ld[1]) begin
            r_s2_x <= r_s1_x;
            r_s2_y <= round_frac(t_sum'(r_s1_p[0]) + t_sum'(r_s1_p[1]));
            r_s2_z <= round_frac(t_sum'(r_s1_p[3]) - t_sum'(r_s1_p[2]));
        end
        // stage 3: products about y, pair (x, -z)
        if (ld[2]) begin
            r_s3_y    <= r_s2_y;
            r_s3_p[0] <= r_s2_x * r_cos[CFG_ANGLE_Y];
            r_s3_p[1] <= s3_nz * r_sin[CFG_ANGLE_Y];
            r_s3_p[2] <= r_s2_x * r_sin[CFG_ANGLE_Y];
            r_s3_p[3] <= s3_nz * r_cos[CFG_ANGLE_Y];
        end
        // stage 4: round x and -z
        if (ld[3]) begin
            r_s4_y  <= r_s3_y;
            r_s4_x  <= round_frac(t_sum'(r_s3_p[0]) + t_sum'(r_s3_p[1]));
            r_s4_nz <= round_frac(t_sum'(r_s3_p[3]) - t_sum'(r_s3_p[2]));
        end
        // stage 5: products about z, pair (x, y)
        if (ld[4]) begin
            r_s5_nz   <= r_s4_nz;
            r_s5_p[0] <= r_s4_x * r_cos[CFG_ANGLE_Z];
            r_s5_p[1] <= r_s4_y * r_sin[CFG_ANGLE_Z];
            r_s5_p[2] <= r_s4_x * r_sin[CFG_ANGLE_Z];
            r_s5_p[3] <= r_s4_y * r_cos[CFG_ANGLE_Z];
        end
        // stage 6: round x and y, restore z, narrow to the result width
        if (ld[5]) begin
            r_s6_x <= OUT_W'(round_frac(t_sum'(r_s5_p[0]) + t_sum'(r_s5_p[1])));
            r_s6_y <= OUT_W'(round_frac(t_sum'(r_s5_p[3]) - t_sum'(r_s5_p[2])));
            r_s6_z <= OUT_W'(-r_s5_nz);
        end
    end

`ifndef SYNTHESIS
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[NSTG-1] |-> s_axis_tready)
        else $error("input stalled while output stage is empty");

    a_zero_angle_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_idx == CFG_ANGLE_Z && i_cfg_data == '0)
        |=> (r_sin[CFG_ANGLE_Z] == '0 && r_cos[CFG_ANGLE_Z] == COS_ONE))
        else $error("zero angle does not give an identity pair");

    a_trig_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sin[CFG_ANGLE_X] <= COS_ONE && r_sin[CFG_ANGLE_X] >= -COS_ONE
         && r_cos[CFG_ANGLE_Y] <= COS_ONE && r_cos[CFG_ANGLE_Y] >= -COS_ONE
         && r_cos[CFG_ANGLE_Z] <= COS_ONE && r_cos[CFG_ANGLE_Z] >= -COS_ONE))
        else $error("trig value outside unit range");
`endif

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the three-axis whole-degree point rotator.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import prxyz_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RAND_ITEMS   = 1300;
    localparam int DIR_N        = 20;
    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = NSTG + 4;
    localparam int MAX_SHOWN    = 10;
    localparam logic [63:0] PI_IN_Q30 = 64'd3373259426;

    // one point request, px in the lowest bits as on s_axis_tdata
    typedef struct packed {
        logic signed [COORD_W-1:0] pz;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] px;
    } t_point;

    // one rotated point, rx in the lowest bits as on m_axis_tdata
    typedef struct packed {
        logic [PAD_W-1:0]        pad;
        logic signed [OUT_W-1:0] rz;
        logic signed [OUT_W-1:0] ry;
        logic signed [OUT_W-1:0] rx;
    } t_rotated;

    // directed stimulus row: angles, point, and a typed-in answer where it is obvious
    typedef struct packed {
        int ax;
        int ay;
        int az;
        int px;
        int py;
        int pz;
        bit typed;
        int ex;
        int ey;
        int ez;
    } t_dir_row;

    typedef enum {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PATTERN} t_rx_mode;

    logic     i_clk    = 1'b0;
    logic     i_rst_n  = 1'b0;
    logic     cfg_we   = 1'b0;
    logic [1:0] cfg_idx = CFG_ANGLE_X;
    logic [ANG_W-1:0] cfg_data = '0;
    logic     s_valid  = 1'b0;
    logic     s_ready;
    t_point   s_data   = '0;
    logic     m_valid;
    logic     m_ready  = 1'b0;
    t_rotated m_data;

    // predictor state: angle copies and the quarter-wave sine table in Q16
    longint   ang_x = 0;
    longint   ang_y = 0;
    longint   ang_z = 0;
    longint   sine_q16 [0:90];

    t_rotated awaited_rotations [$];
    t_rotated next_rotation = '0;
    t_dir_row dir_rows [DIR_N];

    int       cycle_count     = 0;
    int       items_sent      = 0;
    int       results_checked = 0;
    int       mismatches      = 0;
    int       settings_loaded = 0;
    int       holds_done      = 0;
    int       drains_done     = 0;
    bit       hold_req        = 1'b0;

    point_rotate_xyz_degrees dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // sine of d degrees (0..90) in Q30 by a nine-term Taylor series, each step rounded
    function automatic longint quarter_sine_q30(input int unsigned d);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] dv;
        longint      acc;
        if (d == 0) begin
            return 0;
        end
        if (d >= 90) begin
            return longint'(64'd1 << 30);
        end
        x    = (64'(d) * PI_IN_Q30 + 64'd90) / 64'd180;
        x2   = (x * x + (64'd1 << 29)) >> 30;
        term = x;
        acc  = longint'(x);
        for (int k = 1; k <= 8; k++) begin
            dv   = 64'(2 * k) * 64'(2 * k + 1);
            term = (term * x2 + (64'd1 << 29)) >> 30;
            term = (term + dv / 64'd2) / dv;
            if (k % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        return acc;
    endfunction

    // sine of d degrees (0..359) in Q16 from the quarter-wave table
    function automatic longint sine_of_deg(input int unsigned d);
        if (d <= 90) begin
            return sine_q16[d];
        end
        if (d <= 180) begin
            return sine_q16[180 - d];
        end
        if (d <= 270) begin
            return -sine_q16[d - 180];
        end
        return -sine_q16[360 - d];
    endfunction

    // drop the Q16 fraction, halves away from zero
    function automatic longint round_q16(input longint v);
        if (v >= 0) begin
            return (v + 32768) >>> 16;
        end
        return -((-v + 32768) >>> 16);
    endfunction

    // a' = a*cos + b*sin ; b' = -a*sin + b*cos, skipped for whole turns
    function automatic void turn_pair(inout longint a, inout longint b, input longint ang);
        longint      m;
        longint      s;
        longint      c;
        longint      na;
        longint      nb;
        int unsigned d;
        m = ang % 360;
        if (m < 0) begin
            m = m + 360;
        end
        if (m == 0) begin
            return;
        end
        d  = int'(m);
        s  = sine_of_deg(d);
        c  = sine_of_deg((d + 90) % 360);
        na = round_q16(a * c + b * s);
        nb = round_q16(-a * s + b * c);
        a  = na;
        b  = nb;
    endfunction

    // rotate about x, then y (on the pair x, -z), then z
    function automatic t_rotated predict_rotation(input t_point p);
        longint   x;
        longint   y;
        longint   z;
        longint   nz;
        t_rotated r;
        x = p.px;
        y = p.py;
        z = p.pz;
        turn_pair(y, z, ang_x);
        nz = -z;
        turn_pair(x, nz, ang_y);
        z = -nz;
        turn_pair(x, y, ang_z);
        r.pad = '0;
        r.rx  = x[OUT_W-1:0];
        r.ry  = y[OUT_W-1:0];
        r.rz  = z[OUT_W-1:0];
        return r;
    endfunction

    function automatic logic signed [COORD_W-1:0] random_coord(input int unsigned kind);
        case (kind)
            6: return COORD_W'(int'($urandom_range(0, 16)) - 8);
            7: begin
                case ($urandom_range(0, 4))
                    0: return COORD_W'(-32768);
                    1: return COORD_W'(32767);
                    2: return COORD_W'(0);
                    3: return COORD_W'(-1);
                    default: return COORD_W'(1);
                endcase
            end
            9: return COORD_W'(int'($urandom_range(0, 2000)) - 1000);
            default: return COORD_W'($urandom);
        endcase
    endfunction

    // mostly full-range points, with small values, extremes and mixtures
    function automatic t_point random_point();
        int unsigned kind;
        t_point      p;
        kind = $urandom_range(0, 9);
        if (kind == 8) begin
            p.px = random_coord($urandom_range(0, 1) ? 0 : 7);
            p.py = random_coord($urandom_range(0, 1) ? 0 : 7);
            p.pz = random_coord($urandom_range(0, 1) ? 0 : 7);
        end else begin
            p.px = random_coord(kind);
            p.py = random_coord(kind);
            p.pz = random_coord(kind);
        end
        return p;
    endfunction

    function automatic int random_angle();
        case ($urandom_range(0, 7))
            0, 1, 2, 3: return int'($urandom_range(0, 720)) - 360;
            4: begin
                case ($urandom_range(0, 7))
                    0: return 0;
                    1: return 90;
                    2: return 180;
                    3: return 270;
                    4: return -90;
                    5: return -180;
                    6: return 360;
                    default: return -360;
                endcase
            end
            5: return int'($urandom_range(0, 1023)) - 512;
            default: return int'($urandom_range(0, 359));
        endcase
    endfunction

    task automatic note_mismatch(input string what, input bit has_want,
                                 input t_rotated want, input t_rotated got);
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
            if (has_want) begin
                $write("mismatch at cycle %0d (%s): expected x=%0d y=%0d z=%0d pad=%h,",
                       cycle_count, what, want.rx, want.ry, want.rz, want.pad);
                $display(" got x=%0d y=%0d z=%0d pad=%h",
                         got.rx, got.ry, got.rz, got.pad);
            end else begin
                $display("mismatch at cycle %0d (%s): got x=%0d y=%0d z=%0d pad=%h",
                         cycle_count, what, got.rx, got.ry, got.rz, got.pad);
            end
        end
    endtask

    // Scoreboard: queue the expectation of every accepted request first, then
    // match each accepted result against the oldest one, field by field.
    always @(posedge i_clk) begin
        t_rotated want;
        string    diff;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && s_valid && s_ready) begin
            awaited_rotations.push_back(next_rotation);
        end
        if (i_rst_n && m_valid && m_ready) begin
            if (awaited_rotations.size() == 0) begin
                note_mismatch("result with no request waiting", 1'b0, '0, m_data);
            end else begin
                want = awaited_rotations.pop_front();
                diff = "";
                if (m_data.rx !== want.rx) diff = {diff, " rotated_x"};
                if (m_data.ry !== want.ry) diff = {diff, " rotated_y"};
                if (m_data.rz !== want.rz) diff = {diff, " rotated_z"};
                if (m_data.pad !== want.pad) diff = {diff, " pad"};
                if (diff != "") begin
                    note_mismatch({"wrong", diff}, 1'b1, want, m_data);
                end
                results_checked++;
            end
        end
    end

    // Receiver: stall on patterns of random length; on a hold request, hold
    // tready low for a long stretch so the pipe fills and stalls its input.
    initial begin : receiver
        int       seg;
        int       hold_left;
        t_rx_mode mode;
        seg       = 0;
        hold_left = 0;
        mode      = RX_ALWAYS;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                m_ready   <= 1'b0;
                holds_done++;
            end else begin
                if (seg == 0) begin
                    mode = t_rx_mode'($urandom_range(0, 3));
                    seg  = $urandom_range(5, 60);
                end
                seg--;
                case (mode)
                    RX_ALWAYS: m_ready <= 1'b1;
                    RX_COIN:   m_ready <= ($urandom_range(0, 1) == 1);
                    RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:   m_ready <= (seg % 4 != 0);
                endcase
            end
        end
    end

    // Watchdog: end the run if it stalls far beyond the slowest correct run.
    initial begin : watchdog
        wait (cycle_count >= LIMIT_CYCLES);
        $display("timeout after %0d cycles, %0d results still awaited",
                 cycle_count, awaited_rotations.size());
        $display("testbench NOT OK");
        $finish;
    end

    // Offer one request and hold it until accepted; the expectation rides along.
    task automatic send_point(input t_point p, input bit typed, input t_rotated typed_want);
        @(negedge i_clk);
        next_rotation = typed ? typed_want : predict_rotation(p);
        s_valid <= 1'b1;
        s_data  <= p;
        do begin
            @(posedge i_clk);
        end while (!s_ready);
        items_sent++;
    endtask

    // Drop tvalid between requests; n sets the length of the rest.
    task automatic rest(input int n);
        @(negedge i_clk);
        s_valid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // Stop offering, wait for every awaited result, then let the pipe settle.
    task automatic drain_pipe();
        @(negedge i_clk);
        s_valid <= 1'b0;
        while (awaited_rotations.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_angle(input logic [1:0] idx, input int deg);
        logic signed [ANG_W-1:0] v;
        v = deg[ANG_W-1:0];
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= v;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        case (idx)
            CFG_ANGLE_X: ang_x = v;
            CFG_ANGLE_Y: ang_y = v;
            default:     ang_z = v;
        endcase
    endtask

    task automatic load_angles(input int ax, input int ay, input int az);
        set_angle(CFG_ANGLE_X, ax);
        set_angle(CFG_ANGLE_Y, ay);
        set_angle(CFG_ANGLE_Z, az);
        settings_loaded++;
    endtask

    initial begin : stimulus
        t_point   pt;
        t_rotated typed_want;
        int       plen;
        int       burst;
        int       phase;
        bit       gapless;

        for (int d = 0; d <= 90; d++) begin
            sine_q16[d] = (quarter_sine_q30(d) + (64'sd1 <<< 13)) >>> 14;
        end

        // Directed rows: reset angles, extremes, quarter turns, whole turns,
        // angles beyond a full turn, and odd angles that round.
        dir_rows = '{
            '{0, 0, 0,        0, 0, 0,                1, 0, 0, 0},
            '{0, 0, 0,        -32768, 32767, -32768,  1, -32768, 32767, -32768},
            '{0, 0, 0,        32767, -32768, 32767,   1, 32767, -32768, 32767},
            '{90, 0, 0,       -32768, 32767, -32768,  1, -32768, -32768, -32767},
            '{0, 90, 0,       1000, -2000, 3000,      1, -3000, -2000, 1000},
            '{0, 0, 90,       1000, -2000, 3000,      1, -2000, -1000, 3000},
            '{180, 180, 180,  32767, -32768, 12345,   1, 32767, -32768, 12345},
            '{360, -360, 360, -32768, -32768, -32768, 1, -32768, -32768, -32768},
            '{270, 0, 0,      5, 6, 7,                1, 5, -7, 6},
            '{0, 0, -90,      5, 6, 7,                1, -6, 5, 7},
            '{45, 0, 0,       32767, 32767, 32767,    0, 0, 0, 0},
            '{0, -45, 0,      -32768, -32768, -32768, 0, 0, 0, 0},
            '{0, 0, 1,        32767, 0, -1,           0, 0, 0, 0},
            '{511, -512, 359, -32768, 32767, -32768,  0, 0, 0, 0},
            '{-1, -179, -359, 12345, -23456, 30000,   0, 0, 0, 0},
            '{89, 91, 271,    32767, 32767, -32768,   0, 0, 0, 0},
            '{30, 60, 120,    7, -7, 1,               0, 0, 0, 0},
            '{200, 300, 400,  100, -100, 0,           0, 0, 0, 0},
            '{1, 1, 1,        -1, -1, -1,             0, 0, 0, 0},
            '{-360, 360, -360, 21845, -21846, -1,     1, 21845, -21846, -1}
        };

        // hold reset low at the start, then release it once
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Walk the directed table; reload angles only when a row changes them,
        // so the first rows see the values left by reset.
        for (int row = 0; row < DIR_N; row++) begin
            if (dir_rows[row].ax != ang_x || dir_rows[row].ay != ang_y ||
                dir_rows[row].az != ang_z) begin
                drain_pipe();
                load_angles(dir_rows[row].ax, dir_rows[row].ay, dir_rows[row].az);
            end
            pt.px = COORD_W'(dir_rows[row].px);
            pt.py = COORD_W'(dir_rows[row].py);
            pt.pz = COORD_W'(dir_rows[row].pz);
            typed_want.pad = '0;
            typed_want.rx  = OUT_W'(dir_rows[row].ex);
            typed_want.ry  = OUT_W'(dir_rows[row].ey);
            typed_want.rz  = OUT_W'(dir_rows[row].ez);
            send_point(pt, dir_rows[row].typed, typed_want);
            if ($urandom_range(0, 1) == 1) begin
                rest($urandom_range(1, 3));
            end
        end

        // Random phases: new angles while idle, then a run of requests in
        // bursts. Phase 3 holds the receiver off while the sender keeps going;
        // phase 5 pauses the sender mid-run until every result is back.
        phase = 0;
        while (items_sent < DIR_N + RAND_ITEMS) begin
            drain_pipe();
            load_angles(random_angle(), random_angle(), random_angle());
            phase++;
            plen    = $urandom_range(20, 80);
            gapless = (phase % 4 == 2);
            if (phase == 3) begin
                hold_req = 1'b1;
                plen     = 48;
                gapless  = 1'b1;
            end
            burst = $urandom_range(1, 30);
            for (int i = 0; i < plen; i++) begin
                if (phase == 5 && i == plen / 2) begin
                    drain_pipe();
                    drains_done++;
                end
                send_point(random_point(), 1'b0, '0);
                if (!gapless) begin
                    burst--;
                    if (burst == 0) begin
                        rest($urandom_range(1, 12));
                        burst = $urandom_range(1, 30);
                    end
                end
            end
        end

        // wait out the last results, then keep watching for strays
        drain_pipe();
        repeat (4 * SETTLE) @(posedge i_clk);

        $display("covered %0d point requests over %0d angle settings, %0d rotated points checked",
                 items_sent, settings_loaded, results_checked);
        $display("receiver hold-offs %0d, sender drains %0d, mismatches %0d",
                 holds_done, drains_done, mismatches);
        if (mismatches == 0 && awaited_rotations.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/prxyz_pkg.sv
rtl/core/point_rotate_xyz_degrees.sv
tb/sv/testbench.sv
